// File: rtl/pixel_color_distort_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the pixel color distort unit
// Shared concurrent-check shorthands, clocked on the rising edge, reset masked.
// ----------------------------------------------------------------------------
`ifndef PIXEL_COLOR_DISTORT_UNIT_ASSERT_SVH
`define PIXEL_COLOR_DISTORT_UNIT_ASSERT_SVH

// same-cycle implication
`define PCD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PCD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// implication after a fixed number of cycles
`define PCD_ASSERT_LAT(label, clk, rst_n, ante, n, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
        else $error(msg);

`endif

// File: rtl/pcd_pkg.sv
// ----------------------------------------------------------------------------
// pcd_pkg
// Types, register indexes, widths and the sine table for the distort unit.
// ----------------------------------------------------------------------------
package pcd_pkg;

    localparam int CHANNELS   = 3;
    localparam int LANE_W     = 16;
    localparam int PACK_W     = LANE_W * CHANNELS;
    localparam int DIM_W      = 13;
    localparam int POS_W      = 12;
    localparam int DELTA_W    = 14;
    localparam int GAIN_W     = 40;
    localparam int PROD_W     = 48;
    localparam int GAIN_SHIFT = 28;
    localparam int SINE_DEPTH = 65;
    localparam int SINE_IDX_W = 7;
    localparam int SINE_W     = 15;
    localparam int INDEX_W    = 3;

    localparam logic [63:0] PI_Q30 = 64'd3373259426;
    localparam logic signed [GAIN_W-1:0] GAIN_ONE = 40'sh0010000000;

    typedef enum logic [INDEX_W-1:0] {
        REG_OFFSET_GAIN  = 3'd0,
        REG_SINE_GAIN    = 3'd1,
        REG_COLUMN_SLOPE = 3'd2,
        REG_ROW_SLOPE    = 3'd3,
        REG_IMAGE_WIDTH  = 3'd4,
        REG_IMAGE_HEIGHT = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic [PACK_W-1:0] offset_gain;
        logic [PACK_W-1:0] sine_gain;
        logic [PACK_W-1:0] column_slope;
        logic [PACK_W-1:0] row_slope;
        logic [DIM_W-1:0]  image_width;
        logic [DIM_W-1:0]  image_height;
    } cfg_t;

    // round(16384*sin(k*pi/128)), Taylor series in Q2.30, each term truncated
    function automatic logic [SINE_W-1:0] quarter_sine(input logic [SINE_IDX_W-1:0] k);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] acc;
        x    = (64'(k) * PI_Q30) >> 7;
        x2   = (x * x) >> 30;
        term = x;
        acc  = signed'(x);
        term = ((term * x2) >> 30) / 6;
        acc  = acc - signed'(term);
        term = ((term * x2) >> 30) / 20;
        acc  = acc + signed'(term);
        term = ((term * x2) >> 30) / 42;
        acc  = acc - signed'(term);
        term = ((term * x2) >> 30) / 72;
        acc  = acc + signed'(term);
        term = ((term * x2) >> 30) / 110;
        acc  = acc - signed'(term);
        term = ((term * x2) >> 30) / 156;
        acc  = acc + signed'(term);
        term = ((term * x2) >> 30) / 210;
        acc  = acc - signed'(term);
        if (acc < 0)
        begin
            acc = 0;
        end
        return SINE_W'((unsigned'(acc) + 64'h8000) >> 16);
    endfunction

endpackage

// File: rtl/pcd_cfg.sv
// ----------------------------------------------------------------------------
// pcd_cfg
// Configuration register file, written by index from the config channel.
// ----------------------------------------------------------------------------
`include "pixel_color_distort_unit_assert.svh"

module pcd_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    input  logic                         cfg_ready,
    input  logic [pcd_pkg::INDEX_W-1:0]  cfg_index,
    input  logic [pcd_pkg::PACK_W-1:0]   cfg_data,
    output pcd_pkg::cfg_t                cfg
);

    pcd_pkg::cfg_t cfg_reg;
    pcd_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (pcd_pkg::reg_index_t'(cfg_index))
                pcd_pkg::REG_OFFSET_GAIN:  cfg_next.offset_gain  = cfg_data;
                pcd_pkg::REG_SINE_GAIN:    cfg_next.sine_gain    = cfg_data;
                pcd_pkg::REG_COLUMN_SLOPE: cfg_next.column_slope = cfg_data;
                pcd_pkg::REG_ROW_SLOPE:    cfg_next.row_slope    = cfg_data;
                pcd_pkg::REG_IMAGE_WIDTH:
                    cfg_next.image_width  = cfg_data[pcd_pkg::DIM_W-1:0];
                pcd_pkg::REG_IMAGE_HEIGHT:
                    cfg_next.image_height = cfg_data[pcd_pkg::DIM_W-1:0];
                default: ; // drop writes beyond the register list
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.offset_gain  <= '0;
            cfg_reg.sine_gain    <= '0;
            cfg_reg.column_slope <= '0;
            cfg_reg.row_slope    <= '0;
            cfg_reg.image_width  <= pcd_pkg::DIM_W'(512);
            cfg_reg.image_height <= pcd_pkg::DIM_W'(512);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

    `PCD_ASSERT_NXT(a_width_write, clk, rst_n,
        cfg_valid && cfg_ready && cfg_index == pcd_pkg::REG_IMAGE_WIDTH,
        cfg_reg.image_width == $past(cfg_data[pcd_pkg::DIM_W-1:0]),
        "image width transfer not stored")

endmodule

// File: rtl/pcd_lane.sv
// ----------------------------------------------------------------------------
// pcd_lane
// Datapath of one channel: center and sine lookup, gain terms, gain sum,
// scale by the centered value, truncate, clamp and re-bias.
// ----------------------------------------------------------------------------
module pcd_lane (
    input  logic                                clk,
    input  logic [7:0]                          chan,
    input  logic signed [pcd_pkg::DELTA_W-1:0]  dx,
    input  logic signed [pcd_pkg::DELTA_W-1:0]  dy,
    input  logic signed [pcd_pkg::LANE_W-1:0]   off,
    input  logic signed [pcd_pkg::LANE_W-1:0]   sg,
    input  logic signed [pcd_pkg::LANE_W-1:0]   cs,
    input  logic signed [pcd_pkg::LANE_W-1:0]   rs,
    output logic [7:0]                          res
);

    localparam int TERM_W = pcd_pkg::LANE_W + pcd_pkg::DELTA_W;
    localparam int SPROD_W = 2 * pcd_pkg::LANE_W;
    localparam int MAG_W = pcd_pkg::PROD_W - pcd_pkg::GAIN_SHIFT;

    // first quadrant sine table, constant logic
    logic [pcd_pkg::SINE_W-1:0]         sine_rom [pcd_pkg::SINE_DEPTH];

    for (genvar k = 0; k < pcd_pkg::SINE_DEPTH; k++)
    begin : g_rom
        localparam logic [pcd_pkg::SINE_W-1:0] SineEntry =
            pcd_pkg::quarter_sine(pcd_pkg::SINE_IDX_W'(k));
        assign sine_rom[k] = SineEntry;
    end

    // stage 1: center, fold the angle into the first quadrant, look up
    logic signed [7:0]                  c_s1_reg, c_s1_next;
    logic signed [pcd_pkg::LANE_W-1:0]  sin_reg, sin_next;
    logic [7:0]                         mag_c;
    logic [pcd_pkg::SINE_IDX_W-1:0]     rom_idx;

    always_comb
    begin
        c_s1_next = signed'({~chan[7], chan[6:0]});
        mag_c     = c_s1_next[7] ? 8'(-c_s1_next) : 8'(c_s1_next);
        rom_idx   = (mag_c <= 8'd64) ? mag_c[pcd_pkg::SINE_IDX_W-1:0]
                                     : pcd_pkg::SINE_IDX_W'(8'd128 - mag_c);
        sin_next  = c_s1_next[7] ? -signed'(pcd_pkg::LANE_W'(sine_rom[rom_idx]))
                                 :  signed'(pcd_pkg::LANE_W'(sine_rom[rom_idx]));
    end

    // stage 2: gain term products
    logic signed [7:0]                  c_s2_reg;
    logic signed [pcd_pkg::LANE_W-1:0]  off_reg, off_next;
    logic signed [SPROD_W-1:0]          sg_prod_reg, sg_prod_next;
    logic signed [TERM_W-1:0]           cs_prod_reg, cs_prod_next;
    logic signed [TERM_W-1:0]           rs_prod_reg, rs_prod_next;

    always_comb
    begin
        off_next     = off;
        sg_prod_next = SPROD_W'(sg) * SPROD_W'(sin_reg);
        cs_prod_next = TERM_W'(cs) * TERM_W'(dx);
        rs_prod_next = TERM_W'(rs) * TERM_W'(dy);
    end

    // stage 3: gain sum, unit 2^-28
    logic signed [7:0]                  c_s3_reg;
    logic signed [pcd_pkg::GAIN_W-1:0]  gain_reg, gain_next;

    always_comb
    begin
        gain_next = pcd_pkg::GAIN_ONE
                  + (pcd_pkg::GAIN_W'(off_reg) <<< 14)
                  + pcd_pkg::GAIN_W'(sg_prod_reg)
                  + (pcd_pkg::GAIN_W'(cs_prod_reg) <<< 7)
                  + (pcd_pkg::GAIN_W'(rs_prod_reg) <<< 7);
    end

    // stage 4: scale
    logic signed [pcd_pkg::PROD_W-1:0]  prod_reg, prod_next;

    always_comb
    begin
        prod_next = pcd_pkg::PROD_W'(c_s3_reg) * pcd_pkg::PROD_W'(gain_reg);
    end

    // stage 5: truncate toward zero on the magnitude, clamp, re-bias
    logic [pcd_pkg::PROD_W-1:0]  mag_p;
    logic [MAG_W-1:0]            q;
    logic [7:0]                  res_reg, res_next;

    always_comb
    begin
        mag_p = prod_reg[pcd_pkg::PROD_W-1] ? unsigned'(-prod_reg) : unsigned'(prod_reg);
        q     = mag_p[pcd_pkg::PROD_W-1:pcd_pkg::GAIN_SHIFT];
        if (prod_reg[pcd_pkg::PROD_W-1])
        begin
            res_next = (q >= MAG_W'(128)) ? 8'd0 : 8'(MAG_W'(128) - q);
        end
        else
        begin
            res_next = (q >= MAG_W'(127)) ? 8'd255 : 8'(q + MAG_W'(128));
        end
    end

    always_ff @(posedge clk)
    begin
        c_s1_reg    <= c_s1_next;
        sin_reg     <= sin_next;
        c_s2_reg    <= c_s1_reg;
        off_reg     <= off_next;
        sg_prod_reg <= sg_prod_next;
        cs_prod_reg <= cs_prod_next;
        rs_prod_reg <= rs_prod_next;
        c_s3_reg    <= c_s2_reg;
        gain_reg    <= gain_next;
        prod_reg    <= prod_next;
        res_reg     <= res_next;
    end

    assign res = res_reg;

endmodule

// File: rtl/pixel_color_distort_unit.sv
// ----------------------------------------------------------------------------
// pixel_color_distort_unit
// Per-pixel color distortion: gain from offset, sine of the centered byte
// and a linear ramp over column and row, applied per channel and clamped.
//
//   channel   handshake            payload
//   -------   ------------------   ----------------------------------------
//   input     start / busy         chan_zero, chan_one, chan_two, col, row
//   result    done (strobe)        out_zero, out_one, out_two
//   config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One pixel is taken every cycle; busy stays low. Each result passes through
// the five register stages of a lane (lookup, products, gain sum, scale,
// clamp) and comes out with done. rst_n clears the valid bits and loads the
// register defaults asynchronously. The receiver cannot stall, so the
// pipeline advances every cycle; config writes are always taken.
// ----------------------------------------------------------------------------
`include "pixel_color_distort_unit_assert.svh"

module pixel_color_distort_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [7:0]                   chan_zero,
    input  logic [7:0]                   chan_one,
    input  logic [7:0]                   chan_two,
    input  logic [pcd_pkg::POS_W-1:0]    col,
    input  logic [pcd_pkg::POS_W-1:0]    row,
    output logic                         done,
    output logic [7:0]                   out_zero,
    output logic [7:0]                   out_one,
    output logic [7:0]                   out_two,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [pcd_pkg::INDEX_W-1:0]  cfg_index,
    input  logic [pcd_pkg::PACK_W-1:0]   cfg_data
);

    localparam int STAGES = 5;

    pcd_pkg::cfg_t cfg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    pcd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // valid bits travel with the lanes
    logic [STAGES-1:0] vld_reg, vld_next;

    always_comb
    begin
        vld_next = {vld_reg[STAGES-2:0], start && !busy};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign done = vld_reg[STAGES-1];

    // stage 1 position offsets, doubled so odd dimensions stay exact
    logic signed [pcd_pkg::DELTA_W-1:0] dx_reg, dx_next;
    logic signed [pcd_pkg::DELTA_W-1:0] dy_reg, dy_next;

    always_comb
    begin
        dx_next = signed'({1'b0, col, 1'b0}) - signed'({1'b0, cfg.image_width});
        dy_next = signed'({1'b0, row, 1'b0}) - signed'({1'b0, cfg.image_height});
    end

    always_ff @(posedge clk)
    begin
        dx_reg <= dx_next;
        dy_reg <= dy_next;
    end

    logic [7:0] chan_arr [pcd_pkg::CHANNELS];
    logic [7:0] res_arr  [pcd_pkg::CHANNELS];

    assign chan_arr[0] = chan_zero;
    assign chan_arr[1] = chan_one;
    assign chan_arr[2] = chan_two;

    for (genvar i = 0; i < pcd_pkg::CHANNELS; i++)
    begin : g_lane
        pcd_lane u_lane (
            .clk  (clk),
            .chan (chan_arr[i]),
            .dx   (dx_reg),
            .dy   (dy_reg),
            .off  (signed'(cfg.offset_gain [pcd_pkg::LANE_W*i +: pcd_pkg::LANE_W])),
            .sg   (signed'(cfg.sine_gain   [pcd_pkg::LANE_W*i +: pcd_pkg::LANE_W])),
            .cs   (signed'(cfg.column_slope[pcd_pkg::LANE_W*i +: pcd_pkg::LANE_W])),
            .rs   (signed'(cfg.row_slope   [pcd_pkg::LANE_W*i +: pcd_pkg::LANE_W])),
            .res  (res_arr[i])
        );
    end

    assign out_zero = res_arr[0];
    assign out_one  = res_arr[1];
    assign out_two  = res_arr[2];

    `PCD_ASSERT_LAT(a_latency, clk, rst_n, start && !busy, 5, done,
        "input transfer without result five cycles later")
    `PCD_ASSERT_IMP(a_no_orphan, clk, rst_n, done, $past(start && !busy, 5),
        "result strobe without matching input transfer")
    `PCD_ASSERT_LAT(a_mid_gray, clk, rst_n, start && !busy && chan_zero == 8'd128, 5,
        out_zero == 8'd128, "centered byte must stay centered")

endmodule
